// ===== rtl/ntsm_pkg.sv =====
package ntsm_pkg;

  // default ring depth
  localparam int DefaultDepth = 256;

  // register file
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 64;
  localparam int CfgRegW  = 40;
  localparam logic [0:0] REG_WINDOW     = 1'b0;
  localparam logic [0:0] REG_MAX_OFFSET = 1'b1;
  localparam logic [CfgRegW-1:0] WindowReset    = 40'd10000000000;
  localparam logic [CfgRegW-1:0] MaxOffsetReset = 40'd10000000;

  // result status codes
  localparam logic [1:0] STATUS_MATCHED = 2'd0;
  localparam logic [1:0] STATUS_NO_HIT  = 2'd1;
  localparam logic [1:0] STATUS_TOO_FAR = 2'd2;

  localparam int TimeW = 63;
  localparam int QuatW = 64;

  typedef struct packed {
    logic               req_type;
    logic [TimeW-1:0]   sample_time;
    logic signed [15:0] in_qw;
    logic signed [15:0] in_qx;
    logic signed [15:0] in_qy;
    logic signed [15:0] in_qz;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TimeW-1:0]   matched_time;
    logic signed [15:0] out_qw;
    logic signed [15:0] out_qx;
    logic signed [15:0] out_qy;
    logic signed [15:0] out_qz;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_APPEND_CHK,
    ST_APPEND_WR,
    ST_TRIM_ADDR,
    ST_TRIM_RD,
    ST_TRIM_CMP,
    ST_SRCH_ADDR,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_HIT_ADDR,
    ST_HIT_RD,
    ST_HIT_CMP,
    ST_PREV_ADDR,
    ST_PREV_RD,
    ST_PREV_CMP,
    ST_PREV_SEL,
    ST_DIST_CHK,
    ST_MATCH_ADDR,
    ST_MATCH_RD,
    ST_MATCH_DONE,
    ST_NO_HIT,
    ST_TOO_FAR
  } ntsm_state_e;

  // ring offset used to form the store address
  typedef enum logic [2:0] {
    ADDR_MID,
    ADDR_K,
    ADDR_KM1,
    ADDR_PICK,
    ADDR_CNT,
    ADDR_OLDEST
  } addr_sel_e;

  typedef struct packed {
    logic       item_load;
    logic       srch_init;
    logic       srch_step;
    logic       addr_load;
    addr_sel_e  addr_sel;
    logic       mem_write;
    logic       append;
    logic       drop_one;
    logic       hit_load;
    logic       prev_diff;
    logic       prev_sel;
    logic       trim_commit;
    logic       out_load;
    logic [1:0] out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_query;
    logic stale;
    logic cnt_le1;
    logic trim_over;
    logic lo_eq_hi;
    logic k_ge_cnt;
    logic k_zero;
    logic hit_exact;
    logic dist_over;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/nearest_timestamp_sample_matcher_unit.sv =====
// channel   direction  handshake                   beat
// in        input      in_valid_i / in_stall_o     in_item_i  (sample or query)
// out       output     out_valid_o / out_stall_i   out_item_o (one per query)
// cfg       input      apb psel/penable/pwrite     window at 0x0, max offset at 0x8
//
// a stale sample is dropped after its check; otherwise it is written, then entries older
// than the window are trimmed one per pass; a query makes up to clog2(count+1) binary
// search probes, each paying address, store read and compare on the single time store port
// reset clears pointers, count and control; the stores hold garbage until written,
// with no clearing pass
// results sit in an output register: new items are taken while a result waits, and a
// query that finishes early holds its result until the output register frees up
module nearest_timestamp_sample_matcher_unit #(
  parameter int DEPTH = ntsm_pkg::DefaultDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ntsm_pkg::in_item_t             in_item_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ntsm_pkg::out_item_t            out_item_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ntsm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ntsm_pkg::CfgDataW-1:0]  pwdata,
  output logic [ntsm_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import ntsm_pkg::*;

  // config registers, one per 8-byte slot; index is address bit 3
  logic [CfgRegW-1:0] window_q, max_offset_q;
  logic               cfg_wr;
  logic [0:0]         reg_idx;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= WindowReset;
      max_offset_q <= MaxOffsetReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WINDOW:     window_q     <= pwdata[CfgRegW-1:0];
        REG_MAX_OFFSET: max_offset_q <= pwdata[CfgRegW-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended to the bus
  always_comb begin
    case (reg_idx)
      REG_WINDOW:     prdata = CfgDataW'(window_q);
      REG_MAX_OFFSET: prdata = CfgDataW'(max_offset_q);
      default:        prdata = '0;
    endcase
  end

  // sequencer: walks append, trim and search steps
  ntsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // ring stores, pointers, search registers and output register
  ntsm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_item_i    (in_item_i),
    .window_i     (window_q),
    .max_offset_i (max_offset_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== rtl/ntsm_ctrl.sv =====
module ntsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ntsm_pkg::dp_stat_t  stat_i,
  output ntsm_pkg::ctrl_cmd_t cmd_o
);
  import ntsm_pkg::*;

  ntsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.in_query ? ST_SRCH_ADDR : ST_APPEND_CHK;
        end
      end
      ST_APPEND_CHK: state_d = stat_i.stale ? ST_IDLE : ST_APPEND_WR;
      ST_APPEND_WR:  state_d = ST_TRIM_ADDR;
      ST_TRIM_ADDR:  state_d = stat_i.cnt_le1 ? ST_IDLE : ST_TRIM_RD;
      ST_TRIM_RD:    state_d = ST_TRIM_CMP;
      ST_TRIM_CMP:   state_d = stat_i.trim_over ? ST_TRIM_ADDR : ST_IDLE;
      ST_SRCH_ADDR: begin
        if (stat_i.lo_eq_hi) begin
          state_d = stat_i.k_ge_cnt ? ST_NO_HIT : ST_HIT_ADDR;
        end else begin
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD:    state_d = ST_SRCH_CMP;
      ST_SRCH_CMP:   state_d = ST_SRCH_ADDR;
      ST_HIT_ADDR:   state_d = ST_HIT_RD;
      ST_HIT_RD:     state_d = ST_HIT_CMP;
      ST_HIT_CMP: begin
        state_d = (stat_i.hit_exact || stat_i.k_zero) ? ST_DIST_CHK : ST_PREV_ADDR;
      end
      ST_PREV_ADDR:  state_d = ST_PREV_RD;
      ST_PREV_RD:    state_d = ST_PREV_CMP;
      ST_PREV_CMP:   state_d = ST_PREV_SEL;
      ST_PREV_SEL:   state_d = ST_DIST_CHK;
      ST_DIST_CHK:   state_d = stat_i.dist_over ? ST_TOO_FAR : ST_MATCH_ADDR;
      ST_MATCH_ADDR: state_d = ST_MATCH_RD;
      ST_MATCH_RD:   state_d = ST_MATCH_DONE;
      ST_MATCH_DONE, ST_NO_HIT, ST_TOO_FAR: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_OLDEST;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.srch_init = 1'b1;
        end
      end
      ST_APPEND_CHK: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_sel  = ADDR_CNT;
      end
      ST_APPEND_WR: begin
        cmd_o.mem_write = 1'b1;
        cmd_o.append    = 1'b1;
      end
      ST_TRIM_ADDR: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_sel  = ADDR_OLDEST;
      end
      ST_TRIM_CMP: cmd_o.drop_one = stat_i.trim_over;
      ST_SRCH_ADDR: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_sel  = ADDR_MID;
      end
      ST_SRCH_CMP: cmd_o.srch_step = 1'b1;
      ST_HIT_ADDR: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_sel  = ADDR_K;
      end
      ST_HIT_CMP: cmd_o.hit_load = 1'b1;
      ST_PREV_ADDR: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_sel  = ADDR_KM1;
      end
      ST_PREV_CMP: cmd_o.prev_diff = 1'b1;
      ST_PREV_SEL: cmd_o.prev_sel = 1'b1;
      ST_MATCH_ADDR: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_sel  = ADDR_PICK;
      end
      ST_MATCH_DONE: begin
        cmd_o.out_load    = stat_i.out_free;
        cmd_o.trim_commit = stat_i.out_free;
        cmd_o.out_status  = STATUS_MATCHED;
      end
      ST_NO_HIT: begin
        cmd_o.out_load   = stat_i.out_free;
        cmd_o.out_status = STATUS_NO_HIT;
      end
      ST_TOO_FAR: begin
        cmd_o.out_load   = stat_i.out_free;
        cmd_o.out_status = STATUS_TOO_FAR;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/ntsm_dp.sv =====
module ntsm_dp #(
  parameter int DEPTH = ntsm_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ntsm_pkg::ctrl_cmd_t          cmd_i,
  output ntsm_pkg::dp_stat_t           stat_o,
  input  ntsm_pkg::in_item_t           in_item_i,
  input  logic [ntsm_pkg::CfgRegW-1:0] window_i,
  input  logic [ntsm_pkg::CfgRegW-1:0] max_offset_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output ntsm_pkg::out_item_t          out_item_o
);
  import ntsm_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int SumW = PtrW + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(DEPTH - 1);

  // ring stores
  logic [TimeW-1:0] time_mem [DEPTH];
  logic [QuatW-1:0] quat_mem [DEPTH];
  logic [TimeW-1:0] time_rd_q;
  logic [QuatW-1:0] quat_rd_q;

  // ring bookkeeping
  logic [PtrW-1:0]  oldest_q, oldest_inc, addr_q, slot_addr;
  logic [CntW-1:0]  count_q;
  logic [TimeW-1:0] newest_q;

  // search state
  logic [CntW-1:0]  lo_q, hi_q, pick_q, mid, off;
  logic [CntW:0]    lo_hi_sum;
  logic [SumW-1:0]  slot_sum;
  logic [TimeW-1:0] hit_q, prev_q, dprev_q, dhit_q, dist_q;
  logic             rd_lt_qt, prev_closer;

  in_item_t  item_q;
  out_item_t out_q;
  logic      out_valid_q;

  assign lo_hi_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = lo_hi_sum[CntW:1];
  assign oldest_inc = (oldest_q == LastPtr) ? '0 : oldest_q + PtrW'(1);
  assign rd_lt_qt   = time_rd_q < item_q.sample_time;
  assign prev_closer = !(dprev_q > dhit_q);

  // ring offset to store address
  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_MID:    off = mid;
      ADDR_K:      off = lo_q;
      ADDR_KM1:    off = lo_q - CntW'(1);
      ADDR_PICK:   off = pick_q;
      ADDR_CNT:    off = count_q;
      ADDR_OLDEST: off = '0;
      default:     off = '0;
    endcase
    slot_sum  = {1'b0, oldest_q} + SumW'(off);
    if (slot_sum >= DepthSum) begin
      slot_sum = slot_sum - DepthSum;
    end
    slot_addr = slot_sum[PtrW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      time_mem[addr_q] <= item_q.sample_time;
      quat_mem[addr_q] <= {item_q.in_qw, item_q.in_qx, item_q.in_qy, item_q.in_qz};
    end
    time_rd_q <= time_mem[addr_q];
    quat_rd_q <= quat_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        if (count_q == DepthCnt) begin
          oldest_q <= oldest_inc;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end else if (cmd_i.drop_one) begin
        oldest_q <= oldest_inc;
        count_q  <= count_q - CntW'(1);
      end else if (cmd_i.trim_commit) begin
        oldest_q <= addr_q;
        count_q  <= count_q - pick_q;
      end

      if (cmd_i.srch_init) begin
        lo_q <= '0;
        hi_q <= count_q;
      end else if (cmd_i.srch_step) begin
        if (rd_lt_qt) begin
          lo_q <= mid + CntW'(1);
        end else begin
          hi_q <= mid;
        end
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.addr_load) begin
      addr_q <= slot_addr;
    end
    if (cmd_i.append) begin
      newest_q <= item_q.sample_time;
    end
    if (cmd_i.hit_load) begin
      hit_q  <= time_rd_q;
      pick_q <= lo_q;
      dist_q <= time_rd_q - item_q.sample_time;
    end
    if (cmd_i.prev_diff) begin
      prev_q  <= time_rd_q;
      dprev_q <= item_q.sample_time - time_rd_q;
      dhit_q  <= hit_q - item_q.sample_time;
    end
    if (cmd_i.prev_sel) begin
      // ties go to the earlier entry
      if (prev_closer) begin
        pick_q <= lo_q - CntW'(1);
        hit_q  <= prev_q;
        dist_q <= dprev_q;
      end else begin
        dist_q <= dhit_q;
      end
    end
    if (cmd_i.out_load) begin
      out_q.status <= cmd_i.out_status;
      if (cmd_i.out_status == STATUS_MATCHED) begin
        out_q.matched_time <= hit_q;
        out_q.out_qw       <= quat_rd_q[63:48];
        out_q.out_qx       <= quat_rd_q[47:32];
        out_q.out_qy       <= quat_rd_q[31:16];
        out_q.out_qz       <= quat_rd_q[15:0];
      end else begin
        out_q.matched_time <= '0;
        out_q.out_qw       <= '0;
        out_q.out_qx       <= '0;
        out_q.out_qy       <= '0;
        out_q.out_qz       <= '0;
      end
    end
  end

  assign stat_o.in_query  = in_item_i.req_type;
  assign stat_o.stale     = (count_q != '0) && (item_q.sample_time <= newest_q);
  assign stat_o.cnt_le1   = count_q <= CntW'(1);
  assign stat_o.trim_over = (item_q.sample_time - time_rd_q) > TimeW'(window_i);
  assign stat_o.lo_eq_hi  = lo_q == hi_q;
  assign stat_o.k_ge_cnt  = lo_q >= count_q;
  assign stat_o.k_zero    = lo_q == '0;
  assign stat_o.hit_exact = time_rd_q == item_q.sample_time;
  assign stat_o.dist_over = dist_q > TimeW'(max_offset_i);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count beyond ring depth");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= LastPtr)
    else $error("oldest pointer outside ring");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  a_trim_keeps_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop_one |-> count_q > CntW'(1))
    else $error("trim would drop the newest entry");

  a_append_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> count_q != '0)
    else $error("ring empty after append");

endmodule

// ===== verif/tb_nearest_timestamp_sample_matcher_unit.sv =====
`timescale 1ns / 1ps

module tb_nearest_timestamp_sample_matcher_unit;
  import ntsm_pkg::*;

  localparam int RING_DEPTH = DefaultDepth;
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;
  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};
  localparam logic [CfgRegW-1:0] REG_MAX = {CfgRegW{1'b1}};
  // settle time covers a sample trimming a full ring one entry at a time
  localparam int SETTLE_CYCLES = 1000;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  // ring of stored samples and the queue of results it implies
  class sample_ring_checker;
    logic [TimeW-1:0]   time_ring [RING_DEPTH];
    logic [QuatW-1:0]   quat_ring [RING_DEPTH];
    int unsigned        head;
    int unsigned        count;
    int unsigned        miss_cnt;
    logic [CfgRegW-1:0] window;
    logic [CfgRegW-1:0] max_off;
    out_item_t          match_q[$];

    function new();
      head = 0;
      count = 0;
      miss_cnt = 0;
      window = WindowReset;
      max_off = MaxOffsetReset;
    endfunction

    function logic [63:0] time_at(int unsigned k);
      return {1'b0, time_ring[(head + k) % RING_DEPTH]};
    endfunction

    function void drop_front(int unsigned n);
      head = (head + n) % RING_DEPTH;
      count -= n;
    endfunction

    function void flag(string msg);
      miss_cnt++;
      if (miss_cnt <= 10) $display("%s", msg);
    endfunction

    // accepted input beat: update the ring, queue a result for a query
    function void take_item(in_item_t it);
      logic [63:0] t, hit, prev, delta;
      int unsigned k, pick;
      out_item_t res;
      t = {1'b0, it.sample_time};
      if (it.req_type == REQ_SAMPLE) begin
        // stale sample leaves everything alone
        if (count > 0 && t <= time_at(count - 1)) return;
        if (count >= RING_DEPTH) drop_front(1);
        time_ring[(head + count) % RING_DEPTH] = it.sample_time;
        quat_ring[(head + count) % RING_DEPTH] = {it.in_qw, it.in_qx, it.in_qy, it.in_qz};
        count++;
        while (count > 1 && t - time_at(0) > {24'd0, window}) drop_front(1);
        return;
      end
      res = '0;
      k = 0;
      while (k < count && time_at(k) < t) k++;
      if (k >= count) begin
        res.status = STATUS_NO_HIT;
      end else begin
        pick = k;
        hit = time_at(k);
        // ties go to the earlier entry
        if (hit != t && k > 0) begin
          prev = time_at(k - 1);
          if (!(t - prev > hit - t)) pick = k - 1;
        end
        hit = time_at(pick);
        delta = (hit >= t) ? hit - t : t - hit;
        if (delta > {24'd0, max_off}) begin
          res.status = STATUS_TOO_FAR;
        end else begin
          res.status = STATUS_MATCHED;
          res.matched_time = hit[TimeW-1:0];
          {res.out_qw, res.out_qx, res.out_qy, res.out_qz} =
            quat_ring[(head + pick) % RING_DEPTH];
          drop_front(pick);
        end
      end
      match_q.push_back(res);
    endfunction

    function void check_match(out_item_t got);
      out_item_t want;
      if (match_q.size() == 0) begin
        flag($sformatf("result beat with nothing pending: status %0d time %0d",
                       got.status, got.matched_time));
        return;
      end
      want = match_q.pop_front();
      if (got.status !== want.status || got.matched_time !== want.matched_time ||
          got.out_qw !== want.out_qw || got.out_qx !== want.out_qx ||
          got.out_qy !== want.out_qy || got.out_qz !== want.out_qz)
        flag($sformatf({"result mismatch: expected status %0d time %0d q (%0d %0d %0d %0d),",
                        " got status %0d time %0d q (%0d %0d %0d %0d)"},
                       want.status, want.matched_time, want.out_qw, want.out_qx,
                       want.out_qy, want.out_qz, got.status, got.matched_time,
                       got.out_qw, got.out_qx, got.out_qy, got.out_qz));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  sample_ring_checker sb;
  bit          idle_on;
  bit          hold_req;
  int          step_bits;
  int          query_burst;
  int unsigned cycle_cnt = 0;

  nearest_timestamp_sample_matcher_unit #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // both channels sampled at the rising edge; older result checked first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_match(out_item_o);
      if (in_valid_i && !in_stall_o) sb.take_item(in_item_i);
    end
  end

  // result side back-pressure: random bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] rand_bits(int n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (n <= 0) return 64'd0;
    if (n >= 64) return r;
    return r >> (64 - n);
  endfunction

  function automatic in_item_t mk_item(logic req, logic [TimeW-1:0] t, logic [63:0] q);
    in_item_t it;
    it.req_type = req;
    it.sample_time = t;
    {it.in_qw, it.in_qx, it.in_qy, it.in_qz} = q;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it.req_type = r[63];
    it.sample_time = r[62:0];
    r = {$urandom, $urandom};
    {it.in_qw, it.in_qx, it.in_qy, it.in_qz} = r;
    return it;
  endfunction

  // mostly fresh samples, some stale ones and some large forward jumps
  function automatic in_item_t make_sample();
    in_item_t it;
    logic [63:0] newest, t, off;
    int unsigned sel;
    it = noise_item();
    it.req_type = REQ_SAMPLE;
    newest = (sb.count > 0) ? sb.time_at(sb.count - 1) : 64'd0;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      off = $urandom_range(0, 1) ? 64'd0 : rand_bits(step_bits);
      t = (newest > off) ? newest - off : 64'd0;
    end else if (sel < 11) begin
      t = newest + rand_bits(52) + 64'd1;
    end else begin
      t = newest + rand_bits(step_bits) + 64'd1;
    end
    it.sample_time = t[TimeW-1:0];
    return it;
  endfunction

  // queries aimed at stored times: exact, midway, nearby, past the end, before the start, or random
  function automatic in_item_t make_query();
    in_item_t it;
    logic [63:0] base, lo, qt, off;
    int unsigned k, sel;
    it = noise_item();
    it.req_type = REQ_QUERY;
    if (sb.count == 0) return it;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, sb.count - 1);
    base = sb.time_at(k);
    off = rand_bits(step_bits + 1);
    qt = {1'b0, it.sample_time};
    if (sel < 15) begin
      qt = base;
    end else if (sel < 30 && k > 0) begin
      lo = sb.time_at(k - 1);
      qt = lo + ((base - lo) >> 1);
    end else if (sel < 70) begin
      qt = $urandom_range(0, 1) ? base + off : ((base > off) ? base - off : 64'd0);
    end else if (sel < 80) begin
      qt = sb.time_at(sb.count - 1) + 64'd1 + off;
    end else if (sel < 88) begin
      lo = sb.time_at(0);
      qt = (lo > off) ? lo - off : 64'd0;
    end
    it.sample_time = qt[TimeW-1:0];
    return it;
  endfunction

  // one input beat; valid stays high into the next beat unless a gap is drawn
  task automatic drive_item(input in_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.match_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [CfgAddrW-1:0] addr, output logic [CfgDataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [CfgDataW-1:0] rd;
    apb_read({REG_WINDOW, 3'b000}, rd);
    if (rd[CfgRegW-1:0] !== sb.window)
      sb.flag($sformatf("window readback: expected %0d got %0d", sb.window, rd[CfgRegW-1:0]));
    apb_read({REG_MAX_OFFSET, 3'b000}, rd);
    if (rd[CfgRegW-1:0] !== sb.max_off)
      sb.flag($sformatf("max offset readback: expected %0d got %0d",
                        sb.max_off, rd[CfgRegW-1:0]));
  endtask

  // bits above the 40-bit registers carry junk and must be dropped
  task automatic set_regs(input logic [CfgRegW-1:0] win, input logic [CfgRegW-1:0] off);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    apb_write({REG_WINDOW, 3'b000}, {junk[63:CfgRegW], win});
    sb.window = win;
    junk = {$urandom, $urandom};
    apb_write({REG_MAX_OFFSET, 3'b000}, {junk[63:CfgRegW], off});
    sb.max_off = off;
    check_regs();
  endtask

  task automatic run_phase(input logic [CfgRegW-1:0] win, input logic [CfgRegW-1:0] off,
                           input int st, input int n, input bit quiet, input bit squeeze);
    in_item_t it;
    set_regs(win, off);
    step_bits = st;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      // long result hold-off while a run of queries keeps coming
      if (squeeze && i == 30) begin
        hold_req = 1'b1;
        query_burst = 12;
      end
      if (query_burst > 0 || $urandom_range(0, 99) < 35) it = make_query();
      else it = make_sample();
      if (query_burst > 0) query_burst--;
      drive_item(it);
    end
    drain();
  endtask

  initial begin
    int wb, st;
    logic [CfgRegW-1:0] w, o;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    query_burst = 0;
    step_bits = 20;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values of both registers
    check_regs();

    // directed beats at reset settings: window 1e10, max offset 1e7
    drive_item(mk_item(REQ_QUERY, '0, 64'h5a5a_5a5a_5a5a_5a5a));          // empty ring
    drive_item(mk_item(REQ_QUERY, TIME_MAX, 64'ha5a5_a5a5_a5a5_a5a5));    // empty ring
    drive_item(mk_item(REQ_SAMPLE, 63'd0, 64'h8000_7fff_ffff_0000));
    drive_item(mk_item(REQ_SAMPLE, 63'd0, 64'h1111_2222_3333_4444));      // stale, equal
    drive_item(mk_item(REQ_SAMPLE, 63'd1000, 64'h7fff_8000_0000_ffff));
    drive_item(mk_item(REQ_SAMPLE, 63'd500, 64'h0101_0202_0303_0404));    // stale, older
    drive_item(mk_item(REQ_QUERY, 63'd0, 64'hffff_ffff_ffff_ffff));       // exact, oldest
    drive_item(mk_item(REQ_SAMPLE, 63'd3000, 64'h1234_edcb_4567_ba98));
    drive_item(mk_item(REQ_SAMPLE, 63'd5000, 64'hc000_4000_e000_2000));
    drive_item(mk_item(REQ_QUERY, 63'd2000, 64'd0));                      // tie, earlier wins
    drive_item(mk_item(REQ_QUERY, 63'd3100, 64'd0));                      // predecessor nearer
    drive_item(mk_item(REQ_QUERY, 63'd5001, 64'd0));                      // past newest
    drive_item(mk_item(REQ_QUERY, 63'd5000, 64'd0));                      // exact, drops older
    drive_item(mk_item(REQ_SAMPLE, 63'd20005000, 64'h0001_fffe_7ffe_8001));
    drive_item(mk_item(REQ_QUERY, 63'd10005000, 64'd0));                  // tie at the limit
    drive_item(mk_item(REQ_SAMPLE, 63'd50005000, 64'h3c3c_c3c3_0f0f_f0f0));
    drive_item(mk_item(REQ_QUERY, 63'd35005001, 64'd0));                  // too far
    drive_item(mk_item(REQ_SAMPLE, 63'd10000005001, 64'h6666_9999_aaaa_5555)); // trims one
    drive_item(mk_item(REQ_SAMPLE, 63'd10020005000, 64'h0f0f_7777_8888_1e1e)); // span at window
    drive_item(mk_item(REQ_QUERY, TIME_MAX, 64'd0));                      // past newest
    drain();

    // register extremes
    run_phase(40'd0, REG_MAX, 20, 100, 1'b0, 1'b0);
    run_phase(REG_MAX, 40'd0, 30, 100, 1'b0, 1'b0);

    // random windows and offsets, the first one with the long hold-off
    for (int p = 0; p < 3; p++) begin
      wb = $urandom_range(8, 38);
      w = CfgRegW'((64'd1 << wb) | rand_bits(wb));
      st = wb - 5;
      o = CfgRegW'(rand_bits(st + 1));
      run_phase(w, o, st, 100, 1'b0, p == 0);
    end

    // back to reset settings, no idling from here on
    run_phase(WindowReset, MaxOffsetReset, 23, 100, 1'b1, 1'b0);

    // top of the time range
    drive_item(mk_item(REQ_SAMPLE, TIME_MAX, 64'h7fff_7fff_7fff_7fff));
    drive_item(mk_item(REQ_QUERY, TIME_MAX, 64'd0));                      // exact, drops all older
    drive_item(mk_item(REQ_QUERY, 63'd0, 64'd0));                         // too far
    drive_item(mk_item(REQ_SAMPLE, TIME_MAX, 64'h8000_8000_8000_8000));   // stale, equal
    drain();

    if (sb.miss_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ntsm_pkg.sv
rtl/ntsm_ctrl.sv
rtl/ntsm_dp.sv
rtl/nearest_timestamp_sample_matcher_unit.sv
verif/tb_nearest_timestamp_sample_matcher_unit.sv
